@@ hdl/vcsg_pkg.sv @@
// Shared types, codes and constants of the velocity command safety gate.
`default_nettype none

package vcsg_pkg;

    localparam int TIME_BITS      = 48;
    localparam int VEL_BITS       = 32;
    localparam int CFG_BITS       = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int NUM_AXES       = 6;

    localparam logic [CFG_BITS-1:0] INPUT_TIMEOUT_RESET   = CFG_BITS'(500000);
    localparam logic [CFG_BITS-1:0] MANUAL_PRIORITY_RESET = CFG_BITS'(300000);

    typedef enum logic [2:0] {
        MODE_AUTO   = 3'd0,
        MODE_MANUAL = 3'd1,
        MODE_STOP   = 3'd2,
        MODE_RESET  = 3'd3,
        MODE_TICK   = 3'd4
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INPUT_TIMEOUT   = 2'd0,
        CFG_MANUAL_PRIORITY = 2'd1
    } cfg_index_t;

    localparam logic KIND_VEL    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef logic [NUM_AXES-1:0][VEL_BITS-1:0] vel_vec_t;

    // One queued entry: one or two results of a single input item.
    typedef struct packed {
        logic     two_results;
        logic     kind_first;
        logic     kind_second;
        logic     stop_active;
        vel_vec_t vel;
    } entry_t;

endpackage

`default_nettype wire

@@ hdl/velocity_command_safety_gate.sv @@
// Top level of the velocity command safety gate.
//
// Gates autonomous and manual velocity commands, latches an emergency stop and
// answers timer ticks with zero velocity when stopped or when input has gone
// stale. The front end takes one input beat per cycle while the queue is not full
// and updates the gate state at once; each item that gives results leaves one
// entry in a two-entry queue. The back end drains that queue through a single
// output register, one result beat per cycle while the output is ready: an item
// with one result gives one beat, a stop or reset with two results gives two, and
// an item with no result uses an input beat only. Configuration registers are
// written directly out of reset with cfg_wr_en high; indexes 2 and 3 are ignored.
`default_nettype none

module velocity_command_safety_gate (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic [2:0]                               s_mode,
    input  wire logic [vcsg_pkg::TIME_BITS-1:0]           s_time_us,
    input  wire logic                                     s_flag_in,
    input  wire logic signed [vcsg_pkg::VEL_BITS-1:0]     s_linear_x_in,
    input  wire logic signed [vcsg_pkg::VEL_BITS-1:0]     s_linear_y_in,
    input  wire logic signed [vcsg_pkg::VEL_BITS-1:0]     s_linear_z_in,
    input  wire logic signed [vcsg_pkg::VEL_BITS-1:0]     s_angular_x_in,
    input  wire logic signed [vcsg_pkg::VEL_BITS-1:0]     s_angular_y_in,
    input  wire logic signed [vcsg_pkg::VEL_BITS-1:0]     s_angular_z_in,
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic                                          m_kind,
    output logic signed [vcsg_pkg::VEL_BITS-1:0]          m_linear_x_out,
    output logic signed [vcsg_pkg::VEL_BITS-1:0]          m_linear_y_out,
    output logic signed [vcsg_pkg::VEL_BITS-1:0]          m_linear_z_out,
    output logic signed [vcsg_pkg::VEL_BITS-1:0]          m_angular_x_out,
    output logic signed [vcsg_pkg::VEL_BITS-1:0]          m_angular_y_out,
    output logic signed [vcsg_pkg::VEL_BITS-1:0]          m_angular_z_out,
    output logic                                          m_stop_active,
    output logic                                          m_last_of_run,
    input  wire logic                                     cfg_wr_en,
    input  wire logic [vcsg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire logic [vcsg_pkg::CFG_BITS-1:0]            cfg_wdata
);
    import vcsg_pkg::*;

    vel_vec_t in_vel;
    vel_vec_t out_vel;
    entry_t   push_entry;
    entry_t   head_entry;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     head_valid;

    assign in_vel[0] = s_linear_x_in;
    assign in_vel[1] = s_linear_y_in;
    assign in_vel[2] = s_linear_z_in;
    assign in_vel[3] = s_angular_x_in;
    assign in_vel[4] = s_angular_y_in;
    assign in_vel[5] = s_angular_z_in;

    vcsg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_mode    (s_mode),
        .in_time_us (s_time_us),
        .in_flag    (s_flag_in),
        .in_vel     (in_vel),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    vcsg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    vcsg_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_entry      (head_entry),
        .pop             (q_pop),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_kind        (m_kind),
        .out_vel         (out_vel),
        .out_stop_active (m_stop_active),
        .out_last        (m_last_of_run)
    );

    assign m_linear_x_out  = out_vel[0];
    assign m_linear_y_out  = out_vel[1];
    assign m_linear_z_out  = out_vel[2];
    assign m_angular_x_out = out_vel[3];
    assign m_angular_y_out = out_vel[4];
    assign m_angular_z_out = out_vel[5];

endmodule

`default_nettype wire

@@ hdl/vcsg_front.sv @@
// Front end: accepts input beats, keeps the gate state and classifies each item.
`default_nettype none

module vcsg_front (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire logic [2:0]                                 in_mode,
    input  wire logic [vcsg_pkg::TIME_BITS-1:0]             in_time_us,
    input  wire logic                                       in_flag,
    input  wire vcsg_pkg::vel_vec_t                         in_vel,
    input  wire logic                                       cfg_wr_en,
    input  wire logic [vcsg_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  wire logic [vcsg_pkg::CFG_BITS-1:0]              cfg_wdata,
    input  wire logic                                       q_full,
    output logic                                            q_push,
    output vcsg_pkg::entry_t                                q_entry
);
    import vcsg_pkg::*;

    logic [CFG_BITS-1:0]  input_timeout_reg;
    logic [CFG_BITS-1:0]  manual_priority_reg;
    logic                 stop_latched_reg, stop_latched_next;
    logic                 input_seen_reg, input_seen_next;
    logic [TIME_BITS-1:0] last_input_time_reg, last_input_time_next;
    logic                 manual_seen_reg, manual_seen_next;
    logic [TIME_BITS-1:0] last_manual_time_reg, last_manual_time_next;

    logic                 accept;
    logic [TIME_BITS-1:0] manual_age;
    logic [TIME_BITS-1:0] input_age;
    logic                 manual_holds;
    logic                 input_stale;
    logic                 emit;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign manual_age   = in_time_us - last_manual_time_reg;
    assign input_age    = in_time_us - last_input_time_reg;
    assign manual_holds = manual_seen_reg && (manual_age <= TIME_BITS'(manual_priority_reg));
    assign input_stale  = input_seen_reg && (input_age > TIME_BITS'(input_timeout_reg));

    always_comb begin
        stop_latched_next     = stop_latched_reg;
        input_seen_next       = input_seen_reg;
        last_input_time_next  = last_input_time_reg;
        manual_seen_next      = manual_seen_reg;
        last_manual_time_next = last_manual_time_reg;
        emit                  = 1'b0;
        q_entry.two_results   = 1'b0;
        q_entry.kind_first    = KIND_VEL;
        q_entry.kind_second   = KIND_VEL;
        q_entry.stop_active   = stop_latched_reg;
        q_entry.vel           = '0;
        unique case (in_mode)
            MODE_AUTO: begin
                if (!manual_holds) begin
                    emit                 = 1'b1;
                    input_seen_next      = 1'b1;
                    last_input_time_next = in_time_us;
                    if (!stop_latched_reg) begin
                        q_entry.vel = in_vel;
                    end
                end
            end
            MODE_MANUAL: begin
                emit                  = 1'b1;
                input_seen_next       = 1'b1;
                last_input_time_next  = in_time_us;
                manual_seen_next      = 1'b1;
                last_manual_time_next = in_time_us;
                if (!stop_latched_reg) begin
                    q_entry.vel = in_vel;
                end
            end
            MODE_STOP: begin
                if (in_flag) begin
                    emit                = 1'b1;
                    stop_latched_next   = 1'b1;
                    q_entry.stop_active = 1'b1;
                    // status first on a fresh latch, then the zero velocity
                    if (!stop_latched_reg) begin
                        q_entry.two_results = 1'b1;
                        q_entry.kind_first  = KIND_STATUS;
                    end
                end
            end
            MODE_RESET: begin
                if (in_flag) begin
                    emit                = 1'b1;
                    stop_latched_next   = 1'b0;
                    q_entry.stop_active = 1'b0;
                    if (stop_latched_reg) begin
                        q_entry.two_results = 1'b1;
                        q_entry.kind_second = KIND_STATUS;
                    end else begin
                        q_entry.kind_first  = KIND_STATUS;
                    end
                end
            end
            MODE_TICK: begin
                emit = stop_latched_reg || input_stale;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign q_push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_timeout_reg    <= INPUT_TIMEOUT_RESET;
            manual_priority_reg  <= MANUAL_PRIORITY_RESET;
            stop_latched_reg     <= 1'b0;
            input_seen_reg       <= 1'b0;
            last_input_time_reg  <= '0;
            manual_seen_reg      <= 1'b0;
            last_manual_time_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_INPUT_TIMEOUT) begin
                    input_timeout_reg <= cfg_wdata;
                end
                if (cfg_index == CFG_MANUAL_PRIORITY) begin
                    manual_priority_reg <= cfg_wdata;
                end
            end
            if (accept) begin
                stop_latched_reg     <= stop_latched_next;
                input_seen_reg       <= input_seen_next;
                last_input_time_reg  <= last_input_time_next;
                manual_seen_reg      <= manual_seen_next;
                last_manual_time_reg <= last_manual_time_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/vcsg_queue.sv @@
// Two-entry queue between the front end and the result sequencer.
`default_nettype none

module vcsg_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire vcsg_pkg::entry_t  push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output vcsg_pkg::entry_t       head_entry
);
    import vcsg_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/vcsg_back.sv @@
// Back end: unrolls each queued entry into result beats through an output register.
`default_nettype none

module vcsg_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head_valid,
    input  wire vcsg_pkg::entry_t  head_entry,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_kind,
    output vcsg_pkg::vel_vec_t     out_vel,
    output logic                   out_stop_active,
    output logic                   out_last
);
    import vcsg_pkg::*;

    logic     valid_reg;
    logic     phase_reg, phase_next;
    logic     kind_reg;
    vel_vec_t vel_reg;
    logic     stop_reg;
    logic     last_reg;

    logic     load;
    logic     last_next;

    // load a queued entry whenever the output register is empty or its beat leaves now
    assign load      = head_valid && (!valid_reg || out_ready);
    assign last_next = !head_entry.two_results || phase_reg;
    assign pop       = load && last_next;

    always_comb begin
        phase_next = phase_reg;
        if (load) begin
            phase_next = !last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= phase_reg ? head_entry.kind_second : head_entry.kind_first;
            vel_reg  <= head_entry.vel;
            stop_reg <= head_entry.stop_active;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = valid_reg;
    assign out_kind        = kind_reg;
    assign out_vel         = vel_reg;
    assign out_stop_active = stop_reg;
    assign out_last        = last_reg;

endmodule

`default_nettype wire
